// File: sv/tiny_rm_pkg.sv
// Shared constants, operation codes and word types of the tiny register machine unit.
// No dependencies; every other file of the unit but tiny_rm_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tiny_rm_pkg;

    localparam int MEM_WORDS  = 1024;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int REG_COUNT  = 31;
    localparam int REG_AW     = 5;
    localparam int PROG_WORDS = 256;
    localparam int PC_W       = 9;
    localparam int XLEN       = 32;
    localparam int OP_W       = 4;
    localparam int TGT_W      = 8;
    localparam int PADDR_W    = 10;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_LDI     = 4'd1;
    localparam logic [OP_W-1:0] OP_LD      = 4'd2;
    localparam logic [OP_W-1:0] OP_ST      = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD     = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd5;
    localparam logic [OP_W-1:0] OP_MOVI    = 4'd6;
    localparam logic [OP_W-1:0] OP_BRANCH  = 4'd7;
    localparam logic [OP_W-1:0] OP_PRELOAD = 4'd8;

    typedef struct packed {
        logic                    is_preload;
        logic                    is_ld;
        logic                    is_st;
        logic                    is_add;
        logic                    is_mul;
        logic                    is_imm;
        logic                    is_branch;
        logic                    is_unk;
        logic                    rd_ok;
        logic                    rs1_ok;
        logic                    rs2_ok;
        logic [REG_AW-1:0]       dest;
        logic [REG_AW-1:0]       src1;
        logic [REG_AW-1:0]       src2;
        logic signed [XLEN-1:0]  imm;
        logic [TGT_W-1:0]        target;
        logic [PADDR_W-1:0]      paddr;
    } t_req;

    typedef struct packed {
        logic [PC_W-1:0]         next_pc;
        logic                    halted;
        logic                    wrote_reg;
        logic signed [XLEN-1:0]  written_value;
        logic                    mem_written;
        logic                    bad_address;
        logic                    unknown_op;
    } t_result;

endpackage

`default_nettype wire

// File: sv/tiny_register_machine_exec_unit.sv
// Top level: one word in is one decoded instruction, one word out reports its effects.
// An accepted input word passes the input queue, the two execute stages and the output buffer.
// Issue waits while stage one holds a word, set by the register read to write-back loop.
// After reset a clearing pass over all 1024 memory addresses zeroes the data memory and registers;
// no input word is taken during it, while configuration writes are taken as usual.
// Depends on tiny_rm_pkg, tiny_rm_front, tiny_rm_back and tiny_rm_ram.
`timescale 1ns / 1ps
`default_nettype none

module tiny_register_machine_exec_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tiny_rm_pkg::PC_W-1:0]        i_cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // dest_reg, src1_reg, src2_reg, immediate, branch_target, preload_address, zero fill
    input  wire logic [tiny_rm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic [tiny_rm_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // next_pc, halted, wrote_reg, written_value, mem_written, bad_address, unknown_op,
    // zero fill
    output logic [tiny_rm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    import tiny_rm_pkg::*;

    localparam int OUT_PAD = OUT_TDATA_W - (PC_W + XLEN + 5);

    logic [PC_W-1:0]  r_prog_len;
    logic [PC_W-1:0]  eff_len;

    t_req             head;
    logic             head_valid;
    logic             head_pop;
    logic             clearing;
    logic             res_valid;
    t_result          res;

    t_result          r_ob [2];
    logic             r_ob_wp;
    logic             r_ob_rp;
    logic [1:0]       r_ob_cnt;
    logic             ob_pop;
    t_result          ob_head;

    assign eff_len = (r_prog_len > PC_W'(PROG_WORDS)) ? PC_W'(PROG_WORDS) : r_prog_len;

    tiny_rm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_clearing   (clearing),
        .i_head_pop   (head_pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    tiny_rm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_head_pop   (head_pop),
        .i_prog_len   (eff_len),
        .i_out_level  (r_ob_cnt),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_clearing   (clearing)
    );

    assign ob_head       = r_ob[r_ob_rp];
    assign m_axis_tvalid = r_ob_cnt != 2'd0;
    assign ob_pop        = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, ob_head.unknown_op, ob_head.bad_address,
                            ob_head.mem_written, ob_head.written_value, ob_head.wrote_reg,
                            ob_head.halted, ob_head.next_pc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
            r_ob_wp    <= 1'b0;
            r_ob_rp    <= 1'b0;
            r_ob_cnt   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_prog_len <= i_cfg_wdata;
            end
            if (res_valid) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
            if (res_valid && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + 2'd1;
            end else if (!res_valid && ob_pop) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_ob[r_ob_wp] <= res;
        end
    end

    a_ob_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_valid && r_ob_cnt == 2'd2 && !ob_pop))
        else $error("result buffer overflow");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_issue_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_pop |=> !head_pop)
        else $error("issue in consecutive cycles");

    a_result_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_pop |=> ##1 res_valid)
        else $error("result missing two cycles after issue");

endmodule

`default_nettype wire

// File: sv/tiny_rm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tiny_rm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/tiny_rm_front.sv
// Input side: accepts instruction words, decodes the operation and queues them.
// Depends on tiny_rm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tiny_rm_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [tiny_rm_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  wire logic [tiny_rm_pkg::OP_W-1:0]       i_s_tuser,
    input  wire logic                               i_clearing,
    input  wire logic                               i_head_pop,
    output tiny_rm_pkg::t_req                       o_head,
    output logic                                    o_head_valid
);

    import tiny_rm_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    t_req             r_q [QDEPTH];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;
    t_req             n_req;
    logic             push;

    always_comb begin
        n_req            = '0;
        n_req.dest       = i_s_tdata[4:0];
        n_req.src1       = i_s_tdata[9:5];
        n_req.src2       = i_s_tdata[14:10];
        n_req.imm        = i_s_tdata[46:15];
        n_req.target     = i_s_tdata[54:47];
        n_req.paddr      = i_s_tdata[64:55];
        n_req.rd_ok      = 32'(n_req.dest) < REG_COUNT;
        n_req.rs1_ok     = 32'(n_req.src1) < REG_COUNT;
        n_req.rs2_ok     = 32'(n_req.src2) < REG_COUNT;
        unique case (i_s_tuser) inside
            OP_NOP:           ;
            OP_LDI, OP_MOVI:  n_req.is_imm     = 1'b1;
            OP_LD:            n_req.is_ld      = 1'b1;
            OP_ST:            n_req.is_st      = 1'b1;
            OP_ADD:           n_req.is_add     = 1'b1;
            OP_MUL:           n_req.is_mul     = 1'b1;
            OP_BRANCH:        n_req.is_branch  = 1'b1;
            OP_PRELOAD:       n_req.is_preload = 1'b1;
            default:          n_req.is_unk     = 1'b1;
        endcase
    end

    assign o_s_tready   = (r_cnt < QCW'(QDEPTH)) && !i_clearing;
    assign push         = i_s_tvalid && o_s_tready;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = r_cnt != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_head_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !i_head_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_head_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_req;
        end
    end

endmodule

`default_nettype wire

// File: sv/tiny_rm_back.sv
// Execution side: register file, data memory, program counter and the two execute stages.
// Depends on tiny_rm_pkg and tiny_rm_ram.
`timescale 1ns / 1ps
`default_nettype none

module tiny_rm_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tiny_rm_pkg::t_req            i_head,
    input  wire logic                         i_head_valid,
    output logic                              o_head_pop,
    input  wire logic [tiny_rm_pkg::PC_W-1:0] i_prog_len,
    input  wire logic [1:0]                   i_out_level,
    output logic                              o_res_valid,
    output tiny_rm_pkg::t_result              o_res,
    output logic                              o_clearing
);

    import tiny_rm_pkg::*;

    localparam logic [1:0] SRC_VAL = 2'd0;
    localparam logic [1:0] SRC_MEM = 2'd1;
    localparam logic [1:0] SRC_MUL = 2'd2;

    logic                r_clearing;
    logic [MEM_AW-1:0]   r_clr_cnt;
    logic [PC_W-1:0]     r_pc;

    logic                r_s1_v;
    t_req                r_s1;

    logic                r_s2_v;
    logic                r_s2_wr;
    logic [REG_AW-1:0]   r_s2_idx;
    logic [1:0]          r_s2_src;
    logic [XLEN-1:0]     r_s2_val;
    logic [XLEN-1:0]     r_s2_prod;
    logic [PC_W-1:0]     r_s2_npc;
    logic                r_s2_halt;
    logic                r_s2_memw;
    logic                r_s2_bad;
    logic                r_s2_unk;

    logic                r_byp_v;
    logic [REG_AW-1:0]   r_byp_idx;
    logic [XLEN-1:0]     r_byp_val;

    logic [XLEN-1:0]     rf_a_dout;
    logic [XLEN-1:0]     rf_b_dout;
    logic                rf_we;
    logic [REG_AW-1:0]   rf_waddr;
    logic [XLEN-1:0]     rf_wdata;

    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [XLEN-1:0]     mem_wdata;
    logic [XLEN-1:0]     mem_dout;

    logic                issue;
    logic [XLEN-1:0]     s1_a;
    logic [XLEN-1:0]     s1_b;
    logic                s1_run;
    logic                s1_addr_ok;
    logic                s1_pre_ok;
    logic [PC_W-1:0]     n_pc;
    logic                s1_wr;
    logic                s1_memw;
    logic                s1_bad;
    logic                s1_unk;
    logic [1:0]          s1_src;
    logic [XLEN-1:0]     s1_val;
    logic [XLEN-1:0]     s2_val;

    // Issue waits while stage one is occupied; the output buffer must have room for it on arrival.
    assign issue = i_head_valid && !r_s1_v && !r_clearing
                   && ((i_out_level + {1'b0, r_s2_v}) < 2'd2);
    assign o_head_pop = issue;
    assign o_clearing = r_clearing;

    tiny_rm_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (i_head.src1),
        .o_rdata (rf_a_dout)
    );

    tiny_rm_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (i_head.src2),
        .o_rdata (rf_b_dout)
    );

    tiny_rm_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (s1_a[MEM_AW-1:0]),
        .o_rdata (mem_dout)
    );

    always_comb begin
        s1_a = '0;
        s1_b = '0;
        if (r_s1.rs1_ok) begin
            s1_a = (r_byp_v && r_byp_idx == r_s1.src1) ? r_byp_val : rf_a_dout;
        end
        if (r_s1.rs2_ok) begin
            s1_b = (r_byp_v && r_byp_idx == r_s1.src2) ? r_byp_val : rf_b_dout;
        end
        s1_run     = r_pc < i_prog_len;
        s1_addr_ok = s1_a < XLEN'(MEM_WORDS);
        s1_pre_ok  = 32'(r_s1.paddr) < MEM_WORDS;

        if (r_s1.is_preload || !s1_run) begin
            n_pc = r_pc;
        end else if (r_s1.is_branch) begin
            n_pc = PC_W'(r_s1.target);
        end else begin
            n_pc = r_pc + 1'b1;
        end

        s1_wr = !r_s1.is_preload && s1_run && r_s1.rd_ok
                && (r_s1.is_imm || r_s1.is_ld || r_s1.is_add || r_s1.is_mul);
        s1_memw = (r_s1.is_preload && s1_pre_ok)
                  || (!r_s1.is_preload && s1_run && r_s1.is_st && s1_addr_ok);
        s1_bad = (r_s1.is_preload && !s1_pre_ok)
                 || (!r_s1.is_preload && s1_run && (r_s1.is_ld || r_s1.is_st)
                     && !s1_addr_ok);
        s1_unk = !r_s1.is_preload && s1_run && r_s1.is_unk;

        s1_src = SRC_VAL;
        s1_val = '0;
        if (r_s1.is_preload) begin
            s1_val = r_s1.imm;
        end else if (s1_run) begin
            if (r_s1.rd_ok && r_s1.is_imm) begin
                s1_val = r_s1.imm;
            end else if (r_s1.rd_ok && r_s1.is_add) begin
                s1_val = s1_a + s1_b;
            end else if (r_s1.rd_ok && r_s1.is_mul) begin
                s1_src = SRC_MUL;
            end else if (r_s1.rd_ok && r_s1.is_ld && s1_addr_ok) begin
                s1_src = SRC_MEM;
            end else if (r_s1.is_st && s1_addr_ok) begin
                s1_val = s1_b;
            end
        end
    end

    assign mem_we    = r_clearing || (r_s1_v && s1_memw);
    assign mem_waddr = r_clearing ? r_clr_cnt
                     : (r_s1.is_preload ? MEM_AW'(r_s1.paddr) : s1_a[MEM_AW-1:0]);
    assign mem_wdata = r_clearing ? '0 : (r_s1.is_preload ? r_s1.imm : s1_b);

    always_comb begin
        case (r_s2_src)
            SRC_MEM: s2_val = mem_dout;
            SRC_MUL: s2_val = r_s2_prod;
            default: s2_val = r_s2_val;
        endcase
    end

    assign rf_we    = (r_clearing && r_clr_cnt < MEM_AW'(REG_COUNT)) || (r_s2_v && r_s2_wr);
    assign rf_waddr = r_clearing ? r_clr_cnt[REG_AW-1:0] : r_s2_idx;
    assign rf_wdata = r_clearing ? '0 : s2_val;

    assign o_res_valid         = r_s2_v;
    assign o_res.next_pc       = r_s2_npc;
    assign o_res.halted        = r_s2_halt;
    assign o_res.wrote_reg     = r_s2_wr;
    assign o_res.written_value = s2_val;
    assign o_res.mem_written   = r_s2_memw;
    assign o_res.bad_address   = r_s2_bad;
    assign o_res.unknown_op    = r_s2_unk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_pc       <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_byp_v    <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == MEM_AW'(MEM_WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (r_s1_v) begin
                r_pc <= n_pc;
            end
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            if (r_s2_v && r_s2_wr) begin
                r_byp_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= i_head;
        end
        if (r_s1_v) begin
            r_s2_wr   <= s1_wr;
            r_s2_idx  <= r_s1.dest;
            r_s2_src  <= s1_src;
            r_s2_val  <= s1_val;
            r_s2_prod <= s1_a * s1_b;
            r_s2_npc  <= n_pc;
            r_s2_halt <= n_pc >= i_prog_len;
            r_s2_memw <= s1_memw;
            r_s2_bad  <= s1_bad;
            r_s2_unk  <= s1_unk;
        end
        if (r_s2_v && r_s2_wr) begin
            r_byp_idx <= r_s2_idx;
            r_byp_val <= s2_val;
        end
    end

endmodule

`default_nettype wire

// File: sim/tiny_rm_checker.sv
// Checker for the tiny register machine unit: watches both word channels and the length write,
// predicts the result word of every accepted instruction word and compares it field by field.
// Depends on tiny_rm_pkg for widths and operation codes.
`timescale 1ns / 1ps

module tiny_rm_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tiny_rm_pkg::PC_W-1:0]        i_cfg_wdata,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_ready,
    // dest_reg, src1_reg, src2_reg, immediate, branch_target, preload_address, zero fill
    input  wire logic [tiny_rm_pkg::IN_TDATA_W-1:0]  i_in_data,
    // req_type
    input  wire logic [tiny_rm_pkg::OP_W-1:0]        i_in_op,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_ready,
    // next_pc, halted, wrote_reg, written_value, mem_written, bad_address, unknown_op,
    // zero fill
    input  wire logic [tiny_rm_pkg::OUT_TDATA_W-1:0] i_out_data,
    output int                                       o_fail_count,
    output int                                       o_pending
);

    import tiny_rm_pkg::*;

    logic [XLEN-1:0] regs [REG_COUNT];
    logic [XLEN-1:0] dmem [MEM_WORDS];
    logic [PC_W-1:0] pc;
    logic [PC_W-1:0] prog_len;
    t_result         effects_due [$];
    t_result         want_r;
    t_result         seen_r;
    int              fails = 0;

    assign o_fail_count = fails;

    function automatic logic [XLEN-1:0] reg_value(input logic [REG_AW-1:0] idx);
        return (idx < REG_COUNT) ? regs[idx] : '0;
    endfunction

    task automatic predict_effects(input logic [OP_W-1:0] op,
                                   input logic [IN_TDATA_W-1:0] d,
                                   output t_result r);
        logic [REG_AW-1:0]  rd;
        logic [REG_AW-1:0]  rs1;
        logic [REG_AW-1:0]  rs2;
        logic [XLEN-1:0]    imm;
        logic [TGT_W-1:0]   tgt;
        logic [PADDR_W-1:0] paddr;
        logic [PC_W-1:0]    len;
        logic [PC_W-1:0]    npc;
        logic [XLEN-1:0]    addr;
        logic [XLEN-1:0]    v;
        logic [XLEN-1:0]    val;
        logic               writes_reg;
        logic               wrote;
        logic               memw;
        logic               bad;
        logic               unk;
        rd    = d[4:0];
        rs1   = d[9:5];
        rs2   = d[14:10];
        imm   = d[46:15];
        tgt   = d[54:47];
        paddr = d[64:55];
        len   = (prog_len > PROG_WORDS) ? PC_W'(PROG_WORDS) : prog_len;
        npc   = pc;
        v     = '0;
        val   = '0;
        writes_reg = 1'b0;
        wrote = 1'b0;
        memw  = 1'b0;
        bad   = 1'b0;
        unk   = 1'b0;
        if (op == OP_PRELOAD) begin
            if (paddr < MEM_WORDS) begin
                dmem[paddr] = imm;
                memw = 1'b1;
                val  = imm;
            end else begin
                bad = 1'b1;
            end
        end else if (pc < len) begin
            npc = pc + 1'b1;
            case (op)
                OP_NOP: begin
                end
                OP_LDI, OP_MOVI: begin
                    v = imm;
                    writes_reg = 1'b1;
                end
                OP_LD: begin
                    addr = reg_value(rs1);
                    if (addr < MEM_WORDS) begin
                        v = dmem[addr[MEM_AW-1:0]];
                    end else begin
                        bad = 1'b1;
                    end
                    writes_reg = 1'b1;
                end
                OP_ST: begin
                    addr = reg_value(rs1);
                    if (addr < MEM_WORDS) begin
                        val = reg_value(rs2);
                        dmem[addr[MEM_AW-1:0]] = val;
                        memw = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                OP_ADD: begin
                    v = reg_value(rs1) + reg_value(rs2);
                    writes_reg = 1'b1;
                end
                OP_MUL: begin
                    v = reg_value(rs1) * reg_value(rs2);
                    writes_reg = 1'b1;
                end
                OP_BRANCH: begin
                    npc = PC_W'(tgt);
                end
                default: begin
                    unk = 1'b1;
                end
            endcase
            if (writes_reg && rd < REG_COUNT) begin
                regs[rd] = v;
                wrote = 1'b1;
                val   = v;
            end
        end
        pc = npc;
        r.next_pc       = npc;
        r.halted        = (npc >= len);
        r.wrote_reg     = wrote;
        r.written_value = val;
        r.mem_written   = memw;
        r.bad_address   = bad;
        r.unknown_op    = unk;
    endtask

    task automatic check_field(input string name, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] seen);
        if (want !== seen) begin
            fails++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                regs[i] = '0;
            end
            for (int i = 0; i < MEM_WORDS; i++) begin
                dmem[i] = '0;
            end
            pc       = '0;
            prog_len = '0;
            effects_due.delete();
        end else begin
            if (i_cfg_we) begin
                prog_len = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                seen_r.next_pc       = i_out_data[8:0];
                seen_r.halted        = i_out_data[9];
                seen_r.wrote_reg     = i_out_data[10];
                seen_r.written_value = i_out_data[42:11];
                seen_r.mem_written   = i_out_data[43];
                seen_r.bad_address   = i_out_data[44];
                seen_r.unknown_op    = i_out_data[45];
                if (effects_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word: expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want_r = effects_due.pop_front();
                    check_field("next_pc", want_r.next_pc, seen_r.next_pc);
                    check_field("halted", want_r.halted, seen_r.halted);
                    check_field("wrote_reg", want_r.wrote_reg, seen_r.wrote_reg);
                    check_field("written_value", want_r.written_value, seen_r.written_value);
                    check_field("mem_written", want_r.mem_written, seen_r.mem_written);
                    check_field("bad_address", want_r.bad_address, seen_r.bad_address);
                    check_field("unknown_op", want_r.unknown_op, seen_r.unknown_op);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_effects(i_in_op, i_in_data, want_r);
                effects_due = {effects_due, want_r};
            end
        end
        o_pending = effects_due.size();
    end

endmodule

// File: sim/tb_tiny_register_machine_exec_unit.sv
// Testbench top for the tiny register machine unit: drives instruction words in bursts,
// stalls the result channel, writes the program length between phases and gives the verdict.
// Depends on tiny_rm_pkg, tiny_rm_checker and the unit itself.
`timescale 1ns / 1ps

module tb_tiny_register_machine_exec_unit;
    import tiny_rm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNK_FIRST = OP_PRELOAD + 1'b1;
    localparam logic [OP_W-1:0] OP_UNK_LAST  = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [PC_W-1:0]        i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    int          len_cur = 0;
    int unsigned burst_left = 0;
    bit          ready_now;
    int unsigned hold;

    int phase_len   [7] = '{256, 0, 77, 511, 1, 300, 140};
    int phase_items [7] = '{700, 40, 150, 500, 40, 300, 120};

    tiny_register_machine_exec_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tiny_rm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tiny_register_machine_exec_unit regression: fail");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        ready_now = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                if (ready_now) begin
                    ready_now = 1'b0;
                    hold = $urandom_range(1, 8);
                end else begin
                    ready_now = 1'b1;
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(1, 20);
                end
            end
            hold--;
            m_axis_tready <= ready_now;
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [4:0] rd,
                             input logic [4:0] rs1, input logic [4:0] rs2,
                             input logic [31:0] imm, input logic [7:0] tgt,
                             input logic [9:0] paddr);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, paddr, tgt, imm, rs2, rs1, rd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic write_length(input int value);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[PC_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        len_cur = (value > PROG_WORDS) ? PROG_WORDS : value;
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 99) < 75) ? 5'($urandom_range(0, 7))
                                            : 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(0, 31);
        if (r < 45) return $urandom_range(0, MEM_WORDS - 1);
        if (r < 55) return $urandom_range(MEM_WORDS - 4, MEM_WORDS + 4);
        if (r < 65) return 32'hFFFF_FFFF - $urandom_range(0, 3);
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_unknown_op();
        return OP_W'($urandom_range(OP_UNK_FIRST, OP_UNK_LAST));
    endfunction

    task automatic send_random_word();
        int unsigned     pick;
        int unsigned     cap;
        logic [OP_W-1:0] op;
        logic [7:0]      tgt;
        pick = $urandom_range(0, 99);
        if (pick < 13)      op = OP_LDI;
        else if (pick < 20) op = OP_MOVI;
        else if (pick < 35) op = OP_LD;
        else if (pick < 50) op = OP_ST;
        else if (pick < 62) op = OP_ADD;
        else if (pick < 72) op = OP_MUL;
        else if (pick < 80) op = OP_BRANCH;
        else if (pick < 86) op = OP_NOP;
        else if (pick < 93) op = OP_PRELOAD;
        else                op = pick_unknown_op();
        tgt = 8'($urandom_range(0, 255));
        if (op == OP_BRANCH) begin
            // Low targets keep the program counter clear of the permanent end of the program.
            cap = (len_cur > 128) ? 127 : ((len_cur > 0) ? len_cur - 1 : 0);
            tgt = 8'($urandom_range(0, cap));
        end
        send_word(op, pick_reg(), pick_reg(), pick_reg(), pick_value(), tgt,
                  PADDR_W'($urandom_range(0, MEM_WORDS - 1)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NOP;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Program length is zero after reset, so only preload words take effect.
        send_word(OP_NOP,     0,  0,  0,  32'd0,         8'd0,   10'd0);
        send_word(OP_PRELOAD, 31, 31, 31, 32'h8000_0000, 8'hFF,  10'd1023);
        send_word(OP_PRELOAD, 0,  0,  0,  32'hFFFF_FFFF, 8'd0,   10'd0);
        write_length(200);
        send_word(OP_LDI,     0,  0,  0,  32'd1023,      8'd0,   10'd0);
        send_word(OP_LD,      1,  0,  0,  32'd0,         8'd0,   10'd0);
        send_word(OP_LDI,     30, 0,  0,  32'h7FFF_FFFF, 8'd0,   10'd0);
        send_word(OP_ADD,     2,  30, 30, 32'd0,         8'd0,   10'd0);
        send_word(OP_MUL,     3,  1,  30, 32'd0,         8'd0,   10'd0);
        send_word(OP_MUL,     4,  30, 30, 32'd0,         8'd0,   10'd0);
        send_word(OP_MOVI,    31, 0,  0,  32'd5,         8'd0,   10'd0);
        send_word(OP_LDI,     5,  0,  0,  32'hFFFF_FFFF, 8'd0,   10'd0);
        send_word(OP_LD,      6,  5,  0,  32'd0,         8'd0,   10'd0);
        send_word(OP_ST,      0,  5,  30, 32'd0,         8'd0,   10'd0);
        send_word(OP_LDI,     7,  0,  0,  32'd1024,      8'd0,   10'd0);
        send_word(OP_ST,      0,  7,  30, 32'd0,         8'd0,   10'd0);
        send_word(OP_ST,      0,  0,  30, 32'd0,         8'd0,   10'd0);
        send_word(OP_ST,      0,  0,  31, 32'd0,         8'd0,   10'd0);
        send_word(OP_LD,      31, 0,  0,  32'd0,         8'd0,   10'd0);
        send_word(OP_ADD,     8,  31, 2,  32'd0,         8'd0,   10'd0);
        send_word(OP_LD,      9,  31, 0,  32'd0,         8'd0,   10'd0);
        send_word(OP_UNK_FIRST, 0, 0, 0,  32'd0,         8'd0,   10'd0);
        send_word(OP_UNK_LAST,  0, 0, 0,  32'd0,         8'd0,   10'd0);
        send_word(OP_BRANCH,  0,  0,  0,  32'd0,         8'd255, 10'd0);
        send_word(OP_NOP,     0,  0,  0,  32'd0,         8'd0,   10'd0);
        send_word(OP_PRELOAD, 0,  0,  0,  32'h1234_5678, 8'd0,   10'd512);
        write_length(256);
        send_word(OP_BRANCH,  0,  0,  0,  32'd0,         8'd0,   10'd0);

        for (int p = 0; p < 7; p++) begin
            write_length(phase_len[p]);
            for (int n = 0; n < phase_items[p]; n++) begin
                send_random_word();
            end
        end

        // Run off the end of a full-size program so next_pc reaches its top value.
        write_length(256);
        send_word(OP_BRANCH,  0,  0,  0,  32'd0,         8'd255, 10'd0);
        send_word(OP_NOP,     0,  0,  0,  32'd0,         8'd0,   10'd0);
        send_word(OP_NOP,     0,  0,  0,  32'd0,         8'd0,   10'd0);

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tiny_register_machine_exec_unit regression: pass");
        end else begin
            $display("tiny_register_machine_exec_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/tiny_rm_pkg.sv
sv/tiny_rm_ram.sv
sv/tiny_rm_front.sv
sv/tiny_rm_back.sv
sv/tiny_register_machine_exec_unit.sv
sim/tiny_rm_checker.sv
sim/tb_tiny_register_machine_exec_unit.sv
